// ----- design/ssvs_pkg.sv -----
package ssvs_pkg;

    // Fixed widths of the request and result fields.
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;

    // Request types.
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_REPLACE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_PRESENT  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT
    } ctrl_state_t;

    // One result item as it leaves the sequencer.
    typedef struct packed {
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   count;
    } result_t;

endpackage

// ----- design/sorted_sparse_vector_store.sv -----
// Sorted sparse vector store. The block keeps up to CAPACITY (position, value) pairs sorted
// by ascending position in one RAM. A request is taken at a clock edge where start is high
// and busy is low; busy then stays high until the request is finished, and its single result
// is shown on status, slot and entry_count for exactly one cycle with done high. The
// receiver cannot stall the block, so a result must be captured in the cycle that done is
// high. A request whose position is not below vector_length is answered the next cycle. Any
// other request walks the stored entries one per cycle through the RAM read port and one
// shared comparator, and an insert then moves each later entry up one slot, again one per
// cycle, before writing the new pair. An insert at the front of the store is the slowest
// case, and the worst case is an insert at the front of a store that holds CAPACITY - 1
// entries. A full store never shifts. The single read port of the entry RAM sets the pace
// of both walks. vector_length is written through the cfg channel, which is always ready,
// and should only be changed while no request is in flight.
module sorted_sparse_vector_store
    import ssvs_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [POSITION_BITS-1:0] position,
    input  logic signed [VALUE_W-1:0] entry_value,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_W-1:0]        slot,
    output logic [SLOT_W-1:0]        entry_count,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [POSITION_BITS:0]   cfg_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = POSITION_BITS + VALUE_W;

    // The vector length register; positions at or above it are rejected.
    logic [POSITION_BITS:0] vector_length_reg, vector_length_next;

    logic [AW-1:0] ram_raddr, ram_waddr;
    logic [EW-1:0] ram_rdata, ram_wdata;
    logic          ram_we;
    result_t       res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        vector_length_next = vector_length_reg;
        if (cfg_valid && cfg_ready)
        begin
            vector_length_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_length_reg <= '0;
        end
        else
        begin
            vector_length_reg <= vector_length_next;
        end
    end

    // Each RAM word holds one entry: the position in the upper bits, the value below it.
    ssvs_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_entry_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // The sequencer does the search, the shift and the final write.
    ssvs_ctrl #(
        .CAPACITY     (CAPACITY),
        .POSITION_BITS(POSITION_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .position     (position),
        .entry_value  (entry_value),
        .vector_length(vector_length_reg),
        .busy         (busy),
        .res          (res),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata)
    );

    assign done        = res.done;
    assign status      = res.status;
    assign slot        = res.slot;
    assign entry_count = res.count;

    // A result only appears once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is still in work");

    // An out of range request is answered at once and leaves no work behind.
    a_range_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ({1'b0, position} >= vector_length_reg))
        |=> (done && status == STAT_RANGE && slot == '0 && !busy))
        else $error("out of range request not rejected in the next cycle");

    // The entry count never reaches beyond the capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((CAPACITY > 127) || (32'(entry_count) <= CAPACITY)))
        else $error("entry count above capacity");

    // A result carries one of the defined status codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= STAT_FULL))
        else $error("undefined status code");

endmodule

// ----- design/ssvs_ram.sv -----
module ssvs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ssvs_ctrl.sv -----
module ssvs_ctrl
    import ssvs_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int POSITION_BITS = 16,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1),
    localparam int EW = POSITION_BITS + VALUE_W
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     req_type,
    input  logic [POSITION_BITS-1:0] position,
    input  logic [VALUE_W-1:0]       entry_value,
    input  logic [POSITION_BITS:0]   vector_length,
    output logic                     busy,
    output result_t                  res,
    output logic [AW-1:0]            ram_raddr,
    input  logic [EW-1:0]            ram_rdata,
    output logic                     ram_we,
    output logic [AW-1:0]            ram_waddr,
    output logic [EW-1:0]            ram_wdata
);

    ctrl_state_t state_reg, state_next;
    logic                     type_reg, type_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [VALUE_W-1:0]       val_reg, val_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic [CW-1:0]            at_reg, at_next;
    logic                     rvalid_reg, rvalid_next;
    logic [AW-1:0]            ridx_reg, ridx_next;
    logic                     pend_reg, pend_next;
    logic [AW-1:0]            pend_addr_reg, pend_addr_next;
    result_t                  res_reg, res_next;

    logic [POSITION_BITS-1:0] rd_key;
    logic key_eq, key_gt, search_more, exhausted, is_full, in_range, shift_more, shift_done;

    // The one comparator: stored key against the requested position.
    assign rd_key      = ram_rdata[EW-1:VALUE_W];
    assign key_eq      = rvalid_reg && (rd_key == pos_reg);
    assign key_gt      = rvalid_reg && (rd_key > pos_reg);
    assign search_more = idx_reg < count_reg;
    assign exhausted   = !rvalid_reg && !search_more;
    assign is_full     = count_reg >= CW'(CAPACITY);
    assign in_range    = {1'b0, position} < vector_length;
    assign shift_more  = idx_reg > at_reg;
    assign shift_done  = (idx_reg == at_reg) && !pend_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && in_range)
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (type_reg == REQ_REPLACE)
                begin
                    if (key_eq || exhausted)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (key_eq)
                begin
                    state_next = ST_IDLE;
                end
                else if (key_gt || exhausted)
                begin
                    state_next = is_full ? ST_IDLE : ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        type_next      = type_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        at_next        = at_reg;
        rvalid_next    = 1'b0;
        ridx_next      = ridx_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        res_next       = res_reg;
        res_next.done  = 1'b0;
        ram_raddr      = AW'(idx_reg);
        ram_we         = 1'b0;
        ram_waddr      = AW'(at_reg);
        ram_wdata      = {pos_reg, val_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    type_next = req_type;
                    pos_next  = position;
                    val_next  = entry_value;
                    idx_next  = '0;
                    if (!in_range)
                    begin
                        res_next.done   = 1'b1;
                        res_next.status = STAT_RANGE;
                        res_next.slot   = '0;
                        res_next.count  = SLOT_W'(count_reg);
                    end
                end
            end
            ST_SEARCH:
            begin
                // Read one slot per cycle; its key is compared the cycle after.
                if (search_more)
                begin
                    rvalid_next = 1'b1;
                    ridx_next   = AW'(idx_reg);
                    idx_next    = idx_reg + 1'b1;
                end
                res_next.count = SLOT_W'(count_reg);
                if (type_reg == REQ_REPLACE)
                begin
                    if (key_eq)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = ridx_reg;
                        res_next.done   = 1'b1;
                        res_next.status = STAT_OK;
                        res_next.slot   = SLOT_W'(ridx_reg);
                    end
                    else if (exhausted)
                    begin
                        res_next.done   = 1'b1;
                        res_next.status = STAT_NOTFOUND;
                        res_next.slot   = SLOT_W'(count_reg);
                    end
                end
                else if (key_eq)
                begin
                    res_next.done   = 1'b1;
                    res_next.status = STAT_PRESENT;
                    res_next.slot   = SLOT_W'(ridx_reg);
                end
                else if (key_gt || exhausted)
                begin
                    at_next = key_gt ? CW'(ridx_reg) : count_reg;
                    if (is_full)
                    begin
                        res_next.done   = 1'b1;
                        res_next.status = STAT_FULL;
                        res_next.slot   = SLOT_W'(at_next);
                    end
                    else
                    begin
                        // Shift walks down from the top entry.
                        idx_next = count_reg;
                    end
                end
            end
            ST_SHIFT:
            begin
                ram_raddr = AW'(idx_reg - 1'b1);
                if (shift_more)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(idx_reg);
                    idx_next       = idx_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                else if (shift_done)
                begin
                    ram_we          = 1'b1;
                    ram_waddr       = AW'(at_reg);
                    count_next      = count_reg + 1'b1;
                    res_next.done   = 1'b1;
                    res_next.status = STAT_OK;
                    res_next.slot   = SLOT_W'(at_reg);
                    res_next.count  = SLOT_W'(count_next);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            pend_reg   <= pend_next;
            res_reg    <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg      <= type_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        at_reg        <= at_next;
        ridx_reg      <= ridx_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = res_reg;

endmodule

// ----- verif/tb_sorted_sparse_vector_store.sv -----
`timescale 1ns / 1ps

// Testbench for the sorted sparse vector store.
//
// Requests go in on the start/busy handshake. Every accepted item is run at once
// through a predictor that keeps its own sorted copy of the stored pairs. The
// predicted answer is queued, and each done strobe is checked against the oldest
// queued answer. The block cannot hold results off, so the only timing freedom is
// on the sending side. There, idle gaps of random length are put between items,
// so that a new start can land on any cycle of the search and shift walk.
module tb_sorted_sparse_vector_store;

    import ssvs_pkg::*;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 16;
    localparam int ITEMS_PER_PHASE = 230;

    // One result item as the block shows it on its result ports.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [SLOT_W-1:0]   count;
    } answer_t;

    // A directed row either sends a request or writes the vector length.
    typedef enum logic {
        ROW_REQUEST,
        ROW_LENGTH
    } row_kind_t;

    typedef struct {
        row_kind_t       kind;
        logic            rt;
        logic [POS_W-1:0] pos;
        logic [31:0]     val;
        logic [POS_W:0]  len;
        bit              typed;
        answer_t         ans;
    } stim_row_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     start       = 1'b0;
    logic                     req_type    = REQ_INSERT;
    logic [POS_W-1:0]         position    = '0;
    logic signed [VALUE_W-1:0] entry_value = '0;
    logic                     cfg_valid   = 1'b0;
    logic [POS_W:0]           cfg_data    = '0;
    logic                     busy;
    logic                     done;
    logic [STATUS_W-1:0]      status;
    logic [SLOT_W-1:0]        slot;
    logic [SLOT_W-1:0]        entry_count;
    logic                     cfg_ready;

    // Predictor state: the sorted pairs, how many are held, and the length register.
    logic [POS_W-1:0] key_list [CAPACITY];
    logic [31:0]      val_list [CAPACITY];
    int unsigned      fill    = 0;
    logic [POS_W:0]   len_cfg = '0;

    answer_t     pending_answers [$];
    stim_row_t   directed_rows [$];
    int unsigned idle_pct = 0;
    int unsigned errors   = 0;

    sorted_sparse_vector_store #(
        .CAPACITY      (CAPACITY),
        .POSITION_BITS (POS_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .entry_value (entry_value),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .entry_count (entry_count),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Applies one request to the predictor state and returns the answer the block
    // must give. The range check comes first and covers both request types, so a
    // position equal to the length is refused as well. For an insert, an equal
    // position already stored wins over a full store.
    function automatic answer_t answer_request(logic rt, logic [POS_W-1:0] pos,
                                               logic [31:0] val);
        answer_t a;
        int      at;
        int      k;
        a.status = STAT_RANGE;
        a.slot   = '0;
        if ({1'b0, pos} < len_cfg)
        begin
            if (rt == REQ_INSERT)
            begin
                at = 0;
                while (at < fill && key_list[at] < pos)
                    at++;
                a.slot = SLOT_W'(at);
                if (at < fill && key_list[at] == pos)
                    a.status = STAT_PRESENT;
                else if (fill >= CAPACITY)
                    a.status = STAT_FULL;
                else
                begin
                    // Open a hole at the sorted place by moving later pairs up one slot.
                    for (k = fill; k > at; k--)
                    begin
                        key_list[k] = key_list[k - 1];
                        val_list[k] = val_list[k - 1];
                    end
                    key_list[at] = pos;
                    val_list[at] = val;
                    fill++;
                    a.status = STAT_OK;
                end
            end
            else
            begin
                // A miss reports the number of entries searched, which is the fill level.
                a.status = STAT_NOTFOUND;
                a.slot   = SLOT_W'(fill);
                for (k = 0; k < fill; k++)
                begin
                    if (key_list[k] == pos)
                    begin
                        val_list[k] = val;
                        a.status    = STAT_OK;
                        a.slot      = SLOT_W'(k);
                        break;
                    end
                end
            end
        end
        a.count = SLOT_W'(fill);
        return a;
    endfunction

    // Positions lean toward ones already stored (duplicates and replace hits) and
    // toward the length boundary, with the rest spread over the valid range and
    // over the whole field.
    function automatic logic [POS_W-1:0] pick_position();
        int unsigned    coin;
        logic [POS_W:0] border;
        coin = $urandom_range(99);
        if (fill > 0 && coin < 35)
            return key_list[$urandom_range(fill - 1)];
        if (coin < 50)
        begin
            border = len_cfg + (POS_W + 1)'($urandom_range(2)) - 1'b1;
            return border[POS_W-1:0];
        end
        if (len_cfg != 0 && coin < 85)
            return POS_W'($urandom_range(len_cfg - 1));
        return POS_W'($urandom);
    endfunction

    function automatic logic [31:0] pick_value();
        if ($urandom_range(99) >= 15)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Sends one request. The caller is always on a rising edge. Start stays high
    // from one item to the next when no gap is drawn, so it is never lowered and
    // raised again in the same step.
    task automatic send_request(logic rt, logic [POS_W-1:0] pos, logic [31:0] val,
                                bit typed, answer_t typed_ans);
        int unsigned gap;
        answer_t     predicted;
        gap = 0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            gap = $urandom_range(1, 90);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        req_type    <= rt;
        position    <= pos;
        entry_value <= val;
        do
            @(posedge clk);
        while (busy);
        // The item was taken at this edge; the predictor sees it now.
        predicted = answer_request(rt, pos, val);
        pending_answers.push_back(typed ? typed_ans : predicted);
    endtask

    // The length register is only written with the block idle: no answer owed
    // and busy low. Every request gives a result, so nothing can still be running
    // once the queue has drained.
    task automatic write_length(logic [POS_W:0] len);
        start <= 1'b0;
        while (pending_answers.size() != 0 || busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_cfg = len;
    endtask

    function automatic stim_row_t mk_row(row_kind_t kind, logic rt, logic [POS_W-1:0] pos,
                                         logic [31:0] val, logic [POS_W:0] len, bit typed,
                                         logic [STATUS_W-1:0] st, int unsigned at,
                                         int unsigned cnt);
        stim_row_t r;
        r.kind       = kind;
        r.rt         = rt;
        r.pos        = pos;
        r.val        = val;
        r.len        = len;
        r.typed      = typed;
        r.ans.status = st;
        r.ans.slot   = SLOT_W'(at);
        r.ans.count  = SLOT_W'(cnt);
        return r;
    endfunction

    // Every done strobe is checked against the oldest answer still owed.
    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: result with nothing expected, status %0d slot %0d count %0d",
                         $time, status, slot, entry_count);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("status", want.status, status);
                check_field("slot", want.slot, slot);
                check_field("entry_count", want.count, entry_count);
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t        row;
        logic [POS_W:0]   phase_len [8];
        int unsigned      idle_by_phase [4];
        int               p;
        int               n;
        logic             rt;

        // Directed part. While the length is still at its reset value of zero,
        // every request is out of range. Then the full-length extreme, inserts
        // at the two ends of the position field, a duplicate, a replace miss on
        // an empty store, replace hits and misses, and a length set so that a
        // position equal to it is refused for both request types.
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h0000, 32'h7FFF_FFFF,
                                       0, 1, STAT_RANGE, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'hFFFF, 32'h8000_0000,
                                       0, 1, STAT_RANGE, 0, 0));
        directed_rows.push_back(mk_row(ROW_LENGTH, REQ_INSERT, 0, 0, 17'h10000, 0,
                                       STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'h1234, 32'h0000_0000,
                                       0, 1, STAT_NOTFOUND, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'hFFFF, 32'h8000_0000,
                                       0, 1, STAT_OK, 0, 1));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h0000, 32'h7FFF_FFFF,
                                       0, 1, STAT_OK, 0, 2));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'hFFFF, 32'h0000_0000,
                                       0, 1, STAT_PRESENT, 1, 2));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h8000, 32'hFFFF_FFFF,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h7FFF, 32'h5555_5555,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h0001, 32'hAAAA_AAAA,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'hFFFF, 32'h0000_0000,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'h0000, 32'hFFFF_FFFF,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'h0002, 32'h0000_0001,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_LENGTH, REQ_INSERT, 0, 0, 17'h08000, 0,
                                       STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h8000, 32'h0000_0001,
                                       0, 1, STAT_RANGE, 0, 5));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'h8000, 32'h0000_0001,
                                       0, 1, STAT_RANGE, 0, 5));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'h7FFF, 32'h0000_0007,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_LENGTH, REQ_INSERT, 0, 0, 17'h00001, 0,
                                       STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h0000, 32'h0000_0003,
                                       0, 0, STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_INSERT, 16'h0001, 32'h0000_0003,
                                       0, 1, STAT_RANGE, 0, 5));
        directed_rows.push_back(mk_row(ROW_LENGTH, REQ_INSERT, 0, 0, 17'h00000, 0,
                                       STAT_OK, 0, 0));
        directed_rows.push_back(mk_row(ROW_REQUEST, REQ_REPLACE, 16'h0000, 32'h0000_0009,
                                       0, 1, STAT_RANGE, 0, 5));

        // Random phases. A short length first keeps the fill level partial while
        // positions collide often; the long lengths then fill the store, so the
        // later phases hit the full case with the would-be slot anywhere from
        // zero to the capacity.
        phase_len[0] = 17'd40;
        phase_len[1] = 17'h10000;
        phase_len[2] = 17'd300;
        phase_len[3] = 17'd0;
        phase_len[4] = 17'hFFFF;
        phase_len[5] = (POS_W + 1)'($urandom_range(2, 65535));
        phase_len[6] = 17'd1;
        phase_len[7] = 17'h10000;

        // Sender idling per phase. The receiver cannot stall the block, so the
        // phase meant for receiver stalls runs with no idling at all.
        idle_by_phase[0] = 0;
        idle_by_phase[1] = 55;
        idle_by_phase[2] = 0;
        idle_by_phase[3] = 31;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_LENGTH)
                write_length(row.len);
            else
                send_request(row.rt, row.pos, row.val, row.typed, row.ans);
        end

        for (p = 0; p < 8; p++)
        begin
            write_length(phase_len[p]);
            idle_pct = idle_by_phase[p % 4];
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                rt = ($urandom_range(99) < 55) ? REQ_INSERT : REQ_REPLACE;
                send_request(rt, pick_position(), pick_value(), 0, '0);
            end
        end
        start <= 1'b0;

        // Drain what is owed, then leave room for a stray strobe to show up.
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 16) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // The slowest correct run is about 1850 items, each with a full walk of the
    // store and the longest idle gap, which ends well before the watchdog fires.
    initial
    begin : watchdog
        #15_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
